// ===== hdl/mrm_pkg.sv =====
// shared types, codes and crc helper for the modbus rtu register master
`default_nettype none
package mrm_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FUNC_READ      = 8'h03;
    localparam logic [7:0] FUNC_WRITE     = 8'h06;
    localparam logic [7:0] FUNC_WRITE_EXC = 8'h86;
    localparam logic [7:0] READ_BYTE_CNT  = 8'h02;
    localparam logic [7:0] READ_QTY_HI    = 8'h00;
    localparam logic [7:0] READ_QTY_LO    = 8'h01;

    localparam logic [7:0] SLAVE_ID_RESET = 8'h01;

    localparam logic [1:0] ACT_READ    = 2'd0;
    localparam logic [1:0] ACT_WRITE   = 2'd1;
    localparam logic [1:0] ACT_BYTE    = 2'd2;
    localparam logic [1:0] ACT_TIMEOUT = 2'd3;

    localparam logic [1:0] OP_IDLE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_REPLY = 2'd1;
    localparam logic [1:0] STAT_BAD      = 2'd2;
    localparam logic [1:0] STAT_EXC      = 2'd3;

    localparam logic [0:0] KIND_TX  = 1'b0;
    localparam logic [0:0] KIND_CPL = 1'b1;

    localparam logic [2:0] TX_LAST_IDX = 3'd7;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_tx_emit;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [15:0] read_data;
        logic [7:0]  exc_code;
    } t_cpl;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/mrm_tx.sv =====
// request frame serializer with byte-per-cycle crc while i_adv lets it advance
`default_nettype none
module mrm_tx (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire logic             i_write,
    input  wire logic [7:0]       i_slave_id,
    input  wire logic [15:0]      i_reg_addr,
    input  wire logic [15:0]      i_write_value,
    input  wire logic             i_adv,
    output logic                  o_active,
    output mrm_pkg::t_tx_emit     o_emit
);
    import mrm_pkg::*;

    logic        r_active;
    logic [2:0]  r_cnt;
    logic [15:0] r_crc;
    logic [7:0]  r_func;
    logic [15:0] r_reg;
    logic [15:0] r_val;
    logic [7:0]  cur;
    logic        step;

    assign step = r_active && i_adv;

    always_comb begin
        case (r_cnt)
            3'd1:    cur = r_func;
            3'd2:    cur = r_reg[15:8];
            3'd3:    cur = r_reg[7:0];
            3'd4:    cur = r_val[15:8];
            3'd5:    cur = r_val[7:0];
            3'd6:    cur = r_crc[7:0];
            3'd7:    cur = r_crc[15:8];
            default: cur = i_slave_id;
        endcase
    end

    always_comb begin
        o_emit = '0;
        if (i_load) begin
            o_emit.valid = 1'b1;
            o_emit.data  = i_slave_id;
        end else if (step) begin
            o_emit.valid = 1'b1;
            o_emit.data  = cur;
            o_emit.last  = (r_cnt == TX_LAST_IDX);
        end
    end

    assign o_active = r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (i_load) begin
            r_active <= 1'b1;
            r_cnt    <= 3'd1;
        end else if (step) begin
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == TX_LAST_IDX) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_crc  <= crc_byte(CRC_INIT, i_slave_id);
            r_func <= i_write ? FUNC_WRITE : FUNC_READ;
            r_reg  <= i_reg_addr;
            r_val  <= i_write ? i_write_value : {READ_QTY_HI, READ_QTY_LO};
        end else if (step && r_cnt <= 3'd5) begin
            r_crc <= crc_byte(r_crc, cur);
        end
    end

endmodule
`default_nettype wire

// ===== hdl/mrm_rx.sv =====
// reply checker and completion decision
`default_nettype none
module mrm_rx (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire logic        i_write,
    input  wire logic        i_take,
    input  wire logic        i_timeout,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_last,
    input  wire logic [7:0]  i_slave_id,
    output mrm_pkg::t_cpl    o_cpl
);
    import mrm_pkg::*;

    logic [1:0]  r_op;
    logic [15:0] r_crc;
    logic [3:0]  r_cnt;
    logic        r_hdr_bad;
    logic [15:0] r_data;
    logic [7:0]  r_crc_lo;
    logic        r_crc_bad;
    logic [7:0]  r_func;
    logic [7:0]  r_exc;

    logic [15:0] n_crc;
    logic [3:0]  n_cnt;
    logic        n_hdr_bad;
    logic [15:0] n_data;
    logic [7:0]  n_crc_lo;
    logic        n_crc_bad;
    logic [7:0]  n_func;
    logic [7:0]  n_exc;

    logic        wr;
    logic [3:0]  crc_at;
    logic        active;
    logic        finish;

    assign wr     = (r_op == OP_WRITE);
    assign crc_at = wr ? 4'd6 : 4'd5;
    assign active = i_take && (r_op != OP_IDLE);
    assign finish = active && (i_timeout || i_last);

    always_comb begin
        n_crc     = r_crc;
        n_cnt     = r_cnt;
        n_hdr_bad = r_hdr_bad;
        n_data    = r_data;
        n_crc_lo  = r_crc_lo;
        n_crc_bad = r_crc_bad;
        n_func    = r_func;
        n_exc     = r_exc;
        if (active && !i_timeout) begin
            if (r_cnt < crc_at) n_crc = crc_byte(r_crc, i_byte);
            if (r_cnt == 4'd0 && i_byte != i_slave_id) n_hdr_bad = 1'b1;
            if (r_cnt == 4'd1) begin
                n_func = i_byte;
                if (i_byte != (wr ? FUNC_WRITE : FUNC_READ)) n_hdr_bad = 1'b1;
            end
            if (r_cnt == 4'd2) begin
                n_exc = i_byte;
                if (!wr && i_byte != READ_BYTE_CNT) n_hdr_bad = 1'b1;
            end
            if (!wr && r_cnt == 4'd3) n_data[15:8] = i_byte;
            if (!wr && r_cnt == 4'd4) n_data[7:0]  = i_byte;
            if (r_cnt == crc_at) n_crc_lo = i_byte;
            if (r_cnt == crc_at + 4'd1 && r_crc != {i_byte, r_crc_lo}) n_crc_bad = 1'b1;
            if (r_cnt != 4'd15) n_cnt = r_cnt + 4'd1;
        end
    end

    always_comb begin
        o_cpl       = '0;
        o_cpl.valid = finish;
        if (n_cnt == 4'd0) begin
            o_cpl.status = STAT_NO_REPLY;
        end else if (wr) begin
            if (n_cnt >= 4'd8 && !n_hdr_bad && !n_crc_bad) begin
                o_cpl.status = STAT_OK;
            end else if (n_cnt >= 4'd3 && n_func == FUNC_WRITE_EXC) begin
                o_cpl.status   = STAT_EXC;
                o_cpl.exc_code = n_exc;
            end else begin
                o_cpl.status = STAT_BAD;
            end
        end else if (n_cnt >= 4'd7 && !n_hdr_bad && !n_crc_bad) begin
            o_cpl.status    = STAT_OK;
            o_cpl.read_data = n_data;
        end else begin
            o_cpl.status = STAT_BAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op      <= OP_IDLE;
            r_crc     <= CRC_INIT;
            r_cnt     <= '0;
            r_hdr_bad <= 1'b0;
            r_data    <= '0;
            r_crc_lo  <= '0;
            r_crc_bad <= 1'b0;
            r_func    <= '0;
            r_exc     <= '0;
        end else if (i_load || finish) begin
            r_op      <= i_load ? (i_write ? OP_WRITE : OP_READ) : OP_IDLE;
            r_crc     <= CRC_INIT;
            r_cnt     <= '0;
            r_hdr_bad <= 1'b0;
            r_data    <= '0;
            r_crc_lo  <= '0;
            r_crc_bad <= 1'b0;
            r_func    <= '0;
            r_exc     <= '0;
        end else begin
            r_crc     <= n_crc;
            r_cnt     <= n_cnt;
            r_hdr_bad <= n_hdr_bad;
            r_data    <= n_data;
            r_crc_lo  <= n_crc_lo;
            r_crc_bad <= n_crc_bad;
            r_func    <= n_func;
            r_exc     <= n_exc;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/modbus_rtu_register_master_core.sv =====
// modbus rtu register master top level: stream channels, apb config, output register
//
// input stream carries read/write requests, reply bytes and reply timeouts
// (kind in tuser, end of reply in tlast). output stream carries request frame
// bytes (tuser 0, tlast on the eighth byte) and one completion per finished reply
// (tuser 1, tlast 1) with status, read data and exception code.
// a read or write request yields eight transmit bytes, the first one on the
// output in the cycle after the transaction and one per cycle after it while
// the receiver keeps up; s_axis_tready stays low until the eighth byte is
// issued, so no other item enters while a request is being sent.
// reply bytes and timeouts are accepted one per clock while the output is free,
// and a completion appears at the output in the cycle after the closing byte.
// s_axis_tready follows the output register and the serializer: when the receiver
// stalls and the register is full, or request bytes are still going out, input is
// held off; otherwise a new item is taken while the current result is handed over.
// reset (synchronous, active low) empties the output, drops any pending
// request and sets slave_id to 1.
`default_nettype none
module modbus_rtu_register_master_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // reg_addr[15:0], write_value[31:16], reply_byte[39:32]
    input  wire logic [39:0] s_axis_tdata,
    // action[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tx_byte[7:0], status[9:8], read_data[25:10], exception_code[33:26], zero fill
    output logic [39:0]      m_axis_tdata,
    // kind[0]
    output logic             m_axis_tuser,
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mrm_pkg::*;

    logic [7:0]  r_slave_id;
    logic        r_out_valid;
    logic [39:0] r_out_data;
    logic        r_out_kind;
    logic        r_out_last;

    logic        tx_active;
    t_tx_emit    tx_emit;
    t_cpl        cpl;
    logic        out_free;
    logic        accept;
    logic        is_req;
    logic [1:0]  action;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {24'd0, r_slave_id};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_id <= SLAVE_ID_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_slave_id <= pwdata[7:0];
        end
    end

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = out_free && !tx_active;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign action        = s_axis_tuser;
    assign is_req        = (action == ACT_READ) || (action == ACT_WRITE);

    mrm_tx u_tx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (accept && is_req),
        .i_write       (action == ACT_WRITE),
        .i_slave_id    (r_slave_id),
        .i_reg_addr    (s_axis_tdata[15:0]),
        .i_write_value (s_axis_tdata[31:16]),
        .i_adv         (out_free),
        .o_active      (tx_active),
        .o_emit        (tx_emit)
    );

    mrm_rx u_rx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && is_req),
        .i_write    (action == ACT_WRITE),
        .i_take     (accept && !is_req),
        .i_timeout  (action == ACT_TIMEOUT),
        .i_byte     (s_axis_tdata[39:32]),
        .i_last     (s_axis_tlast),
        .i_slave_id (r_slave_id),
        .o_cpl      (cpl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= tx_emit.valid || cpl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (tx_emit.valid) begin
                r_out_data <= {32'd0, tx_emit.data};
                r_out_kind <= KIND_TX;
                r_out_last <= tx_emit.last;
            end else begin
                r_out_data <= {6'd0, cpl.exc_code, cpl.read_data, cpl.status, 8'd0};
                r_out_kind <= KIND_CPL;
                r_out_last <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

// ===== test/tb_modbus_rtu_register_master_core.sv =====
// self-checking testbench for the modbus rtu register master core
module tb_modbus_rtu_register_master_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mrm_pkg::*;

    localparam logic [2:0] REG_SLAVE_ID  = 3'd0;
    localparam logic [7:0] FUNC_READ_EXC = 8'h83;
    localparam int         STALL_LIMIT   = 4000;
    localparam int         ITEMS_PER_PHASE = 38;
    localparam int         PHASES        = 6;

    typedef struct packed {
        logic [1:0]  act;
        logic [15:0] addr;
        logic [15:0] wval;
        logic [7:0]  rbyte;
        logic        rlast;
    } t_link_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx;
        logic        last;
        logic [1:0]  status;
        logic [15:0] data;
        logic [7:0]  exc;
    } t_mb_result;

    typedef struct packed {
        t_link_item  it;
        logic        typed;
        logic [1:0]  status;
        logic [15:0] data;
        logic [7:0]  exc;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    modbus_rtu_register_master_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0]  cfg_slave = SLAVE_ID_RESET;
    logic [1:0]  pend_op = OP_IDLE;
    logic [15:0] crc_run = CRC_INIT;
    logic [3:0]  rx_cnt = '0;
    logic        hdr_bad = 1'b0;
    logic [15:0] rx_word = '0;
    logic [7:0]  crc_lo = '0;
    logic        crc_mis = 1'b0;
    logic [7:0]  rx_func = '0;
    logic [7:0]  rx_exc = '0;

    t_mb_result  pending_results[$];
    int unsigned fails = 0;
    int unsigned items_sent = 0;
    int unsigned quiet_cycles = 0;
    int          tx_gap_pct = 7;
    int          rx_stall_pct = 81;

    t_dir_row directed_rows [25] = '{
        {{ACT_BYTE,    16'h0000, 16'h0000, 8'hFF, 1'b1}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_TIMEOUT, 16'hFFFF, 16'hFFFF, 8'h00, 1'b0}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_READ,    16'h0000, 16'h0000, 8'h00, 1'b0}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_TIMEOUT, 16'h0000, 16'h0000, 8'h00, 1'b0}, 1'b1, STAT_NO_REPLY, 16'h0000, 8'h00},
        {{ACT_WRITE,   16'hFFFF, 16'hFFFF, 8'h00, 1'b0}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_READ,    16'hFFFF, 16'h0000, 8'h00, 1'b0}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_WRITE,   16'h1234, 16'h0000, 8'h00, 1'b0}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_BYTE,    16'h0000, 16'h0000, 8'h01, 1'b0}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_BYTE,    16'h0000, 16'h0000, 8'h86, 1'b0}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_BYTE,    16'h0000, 16'h0000, 8'h04, 1'b1}, 1'b1, STAT_EXC, 16'h0000, 8'h04},
        {{ACT_READ,    16'h00FF, 16'hFFFF, 8'h00, 1'b0}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_BYTE,    16'h0000, 16'h0000, 8'h01, 1'b0}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_BYTE,    16'h0000, 16'h0000, 8'h03, 1'b1}, 1'b1, STAT_BAD, 16'h0000, 8'h00},
        {{ACT_WRITE,   16'hFF00, 16'h00FF, 8'h00, 1'b0}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_BYTE,    16'h0000, 16'h0000, 8'h00, 1'b0}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_TIMEOUT, 16'h0000, 16'h0000, 8'h00, 1'b1}, 1'b1, STAT_BAD, 16'h0000, 8'h00},
        {{ACT_READ,    16'hA5A5, 16'h5A5A, 8'h00, 1'b0}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_BYTE,    16'h0000, 16'h0000, 8'h01, 1'b0}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_BYTE,    16'h0000, 16'h0000, 8'h03, 1'b0}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_BYTE,    16'h0000, 16'h0000, 8'h02, 1'b0}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_BYTE,    16'h0000, 16'h0000, 8'hFF, 1'b0}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_BYTE,    16'h0000, 16'h0000, 8'h00, 1'b0}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_BYTE,    16'h0000, 16'h0000, 8'hFF, 1'b0}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_BYTE,    16'h0000, 16'h0000, 8'hFF, 1'b1}, 1'b0, STAT_OK, 16'h0000, 8'h00},
        {{ACT_BYTE,    16'h0000, 16'h0000, 8'h00, 1'b1}, 1'b0, STAT_OK, 16'h0000, 8'h00}
    };

    function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            r = {1'b0, r[15:1]} ^ ((r[0] ^ b[i]) ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic clear_reply();
        crc_run = CRC_INIT;
        rx_cnt  = '0;
        hdr_bad = 1'b0;
        rx_word = '0;
        crc_lo  = '0;
        crc_mis = 1'b0;
        rx_func = '0;
        rx_exc  = '0;
    endtask

    task automatic master_model_step(input t_link_item it);
        logic [7:0]  frm [8];
        logic [15:0] c;
        logic        wr;
        logic [3:0]  crc_at;
        t_mb_result  r;
        if (it.act == ACT_READ || it.act == ACT_WRITE) begin
            wr = (it.act == ACT_WRITE);
            frm[0] = cfg_slave;
            frm[1] = wr ? FUNC_WRITE : FUNC_READ;
            frm[2] = it.addr[15:8];
            frm[3] = it.addr[7:0];
            frm[4] = wr ? it.wval[15:8] : READ_QTY_HI;
            frm[5] = wr ? it.wval[7:0] : READ_QTY_LO;
            c = CRC_INIT;
            for (int k = 0; k < 6; k++) c = crc16_update(c, frm[k]);
            frm[6] = c[7:0];
            frm[7] = c[15:8];
            for (int k = 0; k < 8; k++) begin
                r = '0;
                r.kind = KIND_TX;
                r.tx = frm[k];
                r.last = (k == 7);
                pending_results.push_back(r);
            end
            pend_op = wr ? OP_WRITE : OP_READ;
            clear_reply();
        end else if (pend_op != OP_IDLE) begin
            wr = (pend_op == OP_WRITE);
            if (it.act == ACT_BYTE) begin
                crc_at = wr ? 4'd6 : 4'd5;
                if (rx_cnt < crc_at) crc_run = crc16_update(crc_run, it.rbyte);
                if (rx_cnt == 4'd0 && it.rbyte != cfg_slave) hdr_bad = 1'b1;
                if (rx_cnt == 4'd1) begin
                    rx_func = it.rbyte;
                    if (it.rbyte != (wr ? FUNC_WRITE : FUNC_READ)) hdr_bad = 1'b1;
                end
                if (rx_cnt == 4'd2) begin
                    rx_exc = it.rbyte;
                    if (!wr && it.rbyte != READ_BYTE_CNT) hdr_bad = 1'b1;
                end
                if (!wr && rx_cnt == 4'd3) rx_word[15:8] = it.rbyte;
                if (!wr && rx_cnt == 4'd4) rx_word[7:0] = it.rbyte;
                if (rx_cnt == crc_at) crc_lo = it.rbyte;
                if (rx_cnt == crc_at + 4'd1 && crc_run != {it.rbyte, crc_lo}) crc_mis = 1'b1;
                if (rx_cnt < 4'd15) rx_cnt = rx_cnt + 4'd1;
            end
            if (it.act == ACT_TIMEOUT || it.rlast) begin
                r = '0;
                r.kind = KIND_CPL;
                r.last = 1'b1;
                if (rx_cnt == 4'd0) begin
                    r.status = STAT_NO_REPLY;
                end else if (wr) begin
                    if (rx_cnt >= 4'd8 && !hdr_bad && !crc_mis) begin
                        r.status = STAT_OK;
                    end else if (rx_cnt >= 4'd3 && rx_func == FUNC_WRITE_EXC) begin
                        r.status = STAT_EXC;
                        r.exc = rx_exc;
                    end else begin
                        r.status = STAT_BAD;
                    end
                end else if (rx_cnt >= 4'd7 && !hdr_bad && !crc_mis) begin
                    r.status = STAT_OK;
                    r.data = rx_word;
                end else begin
                    r.status = STAT_BAD;
                end
                pending_results.push_back(r);
                pend_op = OP_IDLE;
                clear_reply();
            end
        end
    endtask

    // starts and ends at a falling edge
    task automatic push_item(input t_link_item it, input bit counts,
                             input bit use_typed = 1'b0, input t_mb_result typed_res = '0);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {it.rbyte, it.wval, it.addr};
        s_axis_tuser  = it.act;
        s_axis_tlast  = it.rlast;
        do @(posedge i_clk); while (!s_axis_tready);
        master_model_step(it);
        if (use_typed) begin
            void'(pending_results.pop_back());
            pending_results.push_back(typed_res);
        end
        if (counts) items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_slave_id(input logic [7:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = REG_SLAVE_ID;
        pwdata = {24'h0, value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        cfg_slave = value;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {24'h0, value}) begin
            fails++;
            if (fails <= 10)
                $display("slave_id readback: expected %02h got %08h", value, prdata);
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // one request and the reply that follows it, at times after an abandoned request
    task automatic run_exchange();
        t_link_item  it;
        logic [7:0]  rsp[$];
        logic [15:0] c;
        logic        wr;
        logic        use_to;
        int          style;
        int          n;
        if ($urandom_range(0, 9) == 0) begin
            it = '{act: ACT_READ, addr: pick16(), wval: pick16(), rbyte: 8'($urandom),
                   rlast: 1'($urandom)};
            it.act = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
            push_item(it, 1'b1);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
                it = '{act: ACT_BYTE, addr: 16'($urandom), wval: 16'($urandom),
                       rbyte: 8'($urandom), rlast: 1'b0};
                push_item(it, 1'b1);
            end
        end
        wr = 1'($urandom_range(0, 1));
        it = '{act: wr ? ACT_WRITE : ACT_READ, addr: pick16(), wval: pick16(),
               rbyte: 8'($urandom), rlast: 1'($urandom)};
        push_item(it, 1'b1);
        style = $urandom_range(0, 11);
        use_to = 1'b0;
        if (style <= 9) begin
            rsp.push_back(cfg_slave);
            if (style == 7) begin
                rsp.push_back(wr ? FUNC_WRITE_EXC : FUNC_READ_EXC);
                rsp.push_back(8'($urandom_range(1, 255)));
            end else if (wr) begin
                rsp.push_back(FUNC_WRITE);
                rsp.push_back(it.addr[15:8]);
                rsp.push_back(it.addr[7:0]);
                rsp.push_back(it.wval[15:8]);
                rsp.push_back(it.wval[7:0]);
            end else begin
                rsp.push_back(FUNC_READ);
                rsp.push_back(READ_BYTE_CNT);
                c = pick16();
                rsp.push_back(c[15:8]);
                rsp.push_back(c[7:0]);
            end
            c = CRC_INIT;
            foreach (rsp[i]) c = crc16_update(c, rsp[i]);
            rsp.push_back(c[7:0]);
            rsp.push_back(c[15:8]);
        end
        case (style)
            5: begin
                n = $urandom_range(1, 13);
                repeat (n) rsp.push_back(8'($urandom));
            end
            6: use_to = 1'b1;
            8: begin
                n = $urandom_range(0, rsp.size() - 1);
                rsp[n] = rsp[n] ^ (8'h01 << $urandom_range(0, 7));
            end
            9: begin
                n = $urandom_range(1, rsp.size() - 1);
                while (rsp.size() > n) void'(rsp.pop_back());
                use_to = 1'b1;
            end
            10: use_to = 1'b1;
            11: begin
                n = $urandom_range(1, 12);
                repeat (n) rsp.push_back(8'($urandom));
            end
            default: ;
        endcase
        foreach (rsp[i]) begin
            it = '{act: ACT_BYTE, addr: 16'($urandom), wval: 16'($urandom), rbyte: rsp[i],
                   rlast: (i == rsp.size() - 1) && !use_to};
            push_item(it, 1'b1);
        end
        if (use_to) begin
            it = '{act: ACT_TIMEOUT, addr: 16'($urandom), wval: 16'($urandom),
                   rbyte: 8'($urandom), rlast: 1'($urandom)};
            push_item(it, 1'b1);
        end
        // stray traffic while nothing is pending
        if ($urandom_range(0, 9) == 0) begin
            it = '{act: $urandom_range(0, 1) ? ACT_TIMEOUT : ACT_BYTE, addr: 16'($urandom),
                   wval: 16'($urandom), rbyte: 8'($urandom), rlast: 1'($urandom)};
            push_item(it, 1'b0);
        end
    endtask

    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        t_mb_result got;
        t_mb_result want;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind   = m_axis_tuser;
            got.tx     = m_axis_tdata[7:0];
            got.last   = m_axis_tlast;
            got.status = m_axis_tdata[9:8];
            got.data   = m_axis_tdata[25:10];
            got.exc    = m_axis_tdata[33:26];
            if (pending_results.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected transaction: kind %0d tx %02h last %0d",
                             got.kind, got.tx, got.last,
                             " st %0d data %04h exc %02h",
                             got.status, got.data, got.exc);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    fails++;
                    if (fails <= 10)
                        $display("mismatch exp: kind %0d tx %02h last %0d st %0d",
                                 want.kind, want.tx, want.last, want.status,
                                 " data %04h exc %02h", want.data, want.exc,
                                 " | got: kind %0d tx %02h last %0d st %0d",
                                 got.kind, got.tx, got.last, got.status,
                                 " data %04h exc %02h", got.data, got.exc);
                end
            end
        end
    end

    initial begin
        t_mb_result typed;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            typed = '0;
            typed.kind = KIND_CPL;
            typed.last = 1'b1;
            typed.status = directed_rows[i].status;
            typed.data = directed_rows[i].data;
            typed.exc = directed_rows[i].exc;
            push_item(directed_rows[i].it, 1'b0, directed_rows[i].typed, typed);
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0: set_slave_id(8'h00);
                1: set_slave_id(8'hFF);
                default: set_slave_id(8'($urandom));
            endcase
            case (p / 2)
                0: begin tx_gap_pct = 7;  rx_stall_pct = 81; end
                1: begin tx_gap_pct = 81; rx_stall_pct = 7;  end
                default: begin tx_gap_pct = 0; rx_stall_pct = 0; end
            endcase
            while (items_sent < (p + 1) * ITEMS_PER_PHASE) run_exchange();
        end

        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (pending_results.size() != 0) fails += pending_results.size();
        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mrm_pkg.sv
hdl/mrm_tx.sv
hdl/mrm_rx.sv
hdl/modbus_rtu_register_master_core.sv
test/tb_modbus_rtu_register_master_core.sv
